>>> src/gdbg_pkg.sv
// Package for the GPU full-speed/boost governor: beat types, event and
// register codes, reset values and the operating-point count.
// No dependencies.
package gdbg_pkg;

    // Operating-point table size; indexes at or above it saturate
    localparam int unsigned LEVEL_COUNT = 128;

    localparam int unsigned UTIL_W  = 9;
    localparam int unsigned WAIT_W  = 16;
    localparam int unsigned LEVEL_W = 7;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    // Reset values of the configuration registers
    localparam logic [UTIL_W-1:0]  RST_RAISE_THR   = 9'd192;
    localparam logic [UTIL_W-1:0]  RST_RELEASE_THR = 9'd64;
    localparam logic [UTIL_W-1:0]  RST_BOOST_UP    = 9'd233;
    localparam logic [UTIL_W-1:0]  RST_BOOST_DOWN  = 9'd64;
    localparam logic               RST_BOOST_ALLOW = 1'b1;
    localparam logic [WAIT_W-1:0]  RST_WAIT_MS     = 16'd200;
    localparam logic [LEVEL_W-1:0] RST_LOW_INDEX   = 7'd39;
    localparam logic [LEVEL_W-1:0] RST_HIGH_INDEX  = 7'd52;

    typedef enum logic [2:0] {
        EV_NONE         = 3'd0,
        EV_FULL_REQ     = 3'd1,
        EV_FULL_RELEASE = 3'd2,
        EV_BOOST        = 3'd3,
        EV_DEBOOST      = 3'd4
    } t_event;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RAISE_THR   = 3'd0,
        CFG_RELEASE_THR = 3'd1,
        CFG_BOOST_UP    = 3'd2,
        CFG_BOOST_DOWN  = 3'd3,
        CFG_BOOST_ALLOW = 3'd4,
        CFG_WAIT_MS     = 3'd5,
        CFG_LOW_INDEX   = 3'd6,
        CFG_HIGH_INDEX  = 3'd7
    } t_cfg_reg;

    localparam logic MODE_SAMPLE = 1'b0;
    localparam logic MODE_TICK   = 1'b1;

    typedef struct packed {
        logic              mode;
        logic [UTIL_W-1:0] utilization;
    } t_in_beat;

    typedef struct packed {
        logic               full_speed_request;
        logic               boost_on;
        logic               boost_pending;
        logic [LEVEL_W-1:0] level_index;
        t_event             event_res;
    } t_out_beat;

endpackage

>>> src/gpu_dvfs_boost_governor_core.sv
// Top level of the GPU full-speed/boost governor: hysteresis on samples,
// delayed boost timer on ticks, registered result beat.
// Depends on gdbg_pkg.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+---------------------
//  in      | to core   | i_in_valid / o_in_stall   | i_in_data  (t_in_beat)
//  out     | from core | o_out_valid / i_out_stall | o_out_data (t_out_beat)
//  cfg     | to core   | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// One beat per cycle while the output is not stalled: each beat is worked
// out in the cycle it is accepted and its result sits in the output register
// from the next cycle on. The input is stalled only while the output
// register holds a stalled result. Configuration writes are always taken.
// Synchronous active-low reset clears the governor state and loads the
// register defaults; no clearing pass.
module gpu_dvfs_boost_governor_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  gdbg_pkg::t_in_beat                    i_in_data,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output gdbg_pkg::t_out_beat                   o_out_data,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [gdbg_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [gdbg_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    // Configuration registers
    logic [gdbg_pkg::UTIL_W-1:0]  r_raise_thr;
    logic [gdbg_pkg::UTIL_W-1:0]  r_release_thr;
    logic [gdbg_pkg::UTIL_W-1:0]  r_boost_up;
    logic [gdbg_pkg::UTIL_W-1:0]  r_boost_down;
    logic                         r_boost_allow;
    logic [gdbg_pkg::WAIT_W-1:0]  r_wait_ms;
    logic [gdbg_pkg::LEVEL_W-1:0] r_low_index;
    logic [gdbg_pkg::LEVEL_W-1:0] r_high_index;

    // Governor state
    logic                         r_low_req;
    logic                         r_wanted;
    logic                         r_armed;
    logic                         r_active;
    logic [gdbg_pkg::WAIT_W-1:0]  r_wait;

    logic                         n_low_req;
    logic                         n_wanted;
    logic                         n_armed;
    logic                         n_active;
    logic [gdbg_pkg::WAIT_W-1:0]  n_wait;

    // Result register
    logic                         r_out_valid;
    gdbg_pkg::t_out_beat          r_out;
    gdbg_pkg::t_out_beat          n_out;

    logic                         in_accept;
    logic                         cfg_write;
    logic                         skip_boost;
    gdbg_pkg::t_event             n_event;
    logic [gdbg_pkg::LEVEL_W-1:0] raw_index;
    logic [gdbg_pkg::UTIL_W-1:0]  util;

    assign o_in_stall  = r_out_valid & i_out_stall;
    assign in_accept   = i_in_valid & ~o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign cfg_write   = i_cfg_valid & o_cfg_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign util        = i_in_data.utilization;

    // Work out the next state and the result for the beat on the input
    always_comb begin
        n_low_req  = r_low_req;
        n_wanted   = r_wanted;
        n_armed    = r_armed;
        n_active   = r_active;
        n_wait     = r_wait;
        n_event    = gdbg_pkg::EV_NONE;
        skip_boost = 1'b0;

        if (i_in_data.mode == gdbg_pkg::MODE_TICK) begin
            // Count down an armed change; apply it when it runs out
            if (r_armed) begin
                if (r_wait <= gdbg_pkg::WAIT_W'(1)) begin
                    n_active = r_wanted;
                    n_armed  = 1'b0;
                    n_wait   = '0;
                    n_event  = r_wanted ? gdbg_pkg::EV_BOOST : gdbg_pkg::EV_DEBOOST;
                end else begin
                    n_wait = r_wait - gdbg_pkg::WAIT_W'(1);
                end
            end
        end else begin
            // Hysteresis on the full-speed request
            if ((!r_wanted && !r_active && !r_armed) || !r_boost_allow) begin
                if (util > r_raise_thr) begin
                    if (r_low_req) begin
                        n_low_req  = 1'b0;
                        n_event    = gdbg_pkg::EV_FULL_REQ;
                        skip_boost = 1'b1;
                    end
                end else if (util < r_release_thr) begin
                    if (!r_low_req) begin
                        n_low_req = 1'b1;
                        n_event   = gdbg_pkg::EV_FULL_RELEASE;
                    end
                end
            end

            // Arm, cancel or re-arm the delayed boost change
            if (!skip_boost && !n_low_req && r_boost_allow) begin
                if (!r_wanted && util > r_boost_up) begin
                    n_wanted = 1'b1;
                    if (!r_armed) begin
                        n_armed = 1'b1;
                        n_wait  = r_wait_ms;
                    end else begin
                        n_armed = 1'b0;
                        n_wait  = '0;
                    end
                end else if (r_wanted && !r_active && util < r_boost_down) begin
                    n_wanted = 1'b0;
                    if (r_armed) begin
                        n_armed = 1'b0;
                        n_wait  = '0;
                    end
                end else if (r_active && util < r_boost_down) begin
                    n_wanted = 1'b0;
                    if (!r_armed) begin
                        n_armed = 1'b1;
                        n_wait  = r_wait_ms;
                    end
                end
            end
        end

        // Pick the operating point and saturate it to the table size
        raw_index = n_active ? r_high_index : r_low_index;
        if ({{(gdbg_pkg::UTIL_W - gdbg_pkg::LEVEL_W){1'b0}}, raw_index}
                >= gdbg_pkg::UTIL_W'(gdbg_pkg::LEVEL_COUNT)) begin
            raw_index = gdbg_pkg::LEVEL_W'(gdbg_pkg::LEVEL_COUNT - 1);
        end

        n_out.full_speed_request = ~n_low_req;
        n_out.boost_on           = n_active;
        n_out.boost_pending      = n_armed;
        n_out.level_index        = raw_index;
        n_out.event_res          = n_event;
    end

    // Advance governor state on an accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_req <= 1'b1;
            r_wanted  <= 1'b0;
            r_armed   <= 1'b0;
            r_active  <= 1'b0;
            r_wait    <= '0;
        end else if (in_accept) begin
            r_low_req <= n_low_req;
            r_wanted  <= n_wanted;
            r_armed   <= n_armed;
            r_active  <= n_active;
            r_wait    <= n_wait;
        end
    end

    // Hold the result until the far side takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= in_accept | (r_out_valid & i_out_stall);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out <= n_out;
        end
    end

    // Configuration register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raise_thr   <= gdbg_pkg::RST_RAISE_THR;
            r_release_thr <= gdbg_pkg::RST_RELEASE_THR;
            r_boost_up    <= gdbg_pkg::RST_BOOST_UP;
            r_boost_down  <= gdbg_pkg::RST_BOOST_DOWN;
            r_boost_allow <= gdbg_pkg::RST_BOOST_ALLOW;
            r_wait_ms     <= gdbg_pkg::RST_WAIT_MS;
            r_low_index   <= gdbg_pkg::RST_LOW_INDEX;
            r_high_index  <= gdbg_pkg::RST_HIGH_INDEX;
        end else if (cfg_write) begin
            case (gdbg_pkg::t_cfg_reg'(i_cfg_index))
                gdbg_pkg::CFG_RAISE_THR:   r_raise_thr   <= i_cfg_data[gdbg_pkg::UTIL_W-1:0];
                gdbg_pkg::CFG_RELEASE_THR: r_release_thr <= i_cfg_data[gdbg_pkg::UTIL_W-1:0];
                gdbg_pkg::CFG_BOOST_UP:    r_boost_up    <= i_cfg_data[gdbg_pkg::UTIL_W-1:0];
                gdbg_pkg::CFG_BOOST_DOWN:  r_boost_down  <= i_cfg_data[gdbg_pkg::UTIL_W-1:0];
                gdbg_pkg::CFG_BOOST_ALLOW: r_boost_allow <= i_cfg_data[0];
                gdbg_pkg::CFG_WAIT_MS:     r_wait_ms     <= i_cfg_data[gdbg_pkg::WAIT_W-1:0];
                gdbg_pkg::CFG_LOW_INDEX:   r_low_index   <= i_cfg_data[gdbg_pkg::LEVEL_W-1:0];
                gdbg_pkg::CFG_HIGH_INDEX:  r_high_index  <= i_cfg_data[gdbg_pkg::LEVEL_W-1:0];
                default: begin
                end
            endcase
        end
    end

endmodule

>>> src/gdbg_chk.sv
// Port-level checker for the GPU full-speed/boost governor, bound to the
// top level. Depends on gdbg_pkg and gpu_dvfs_boost_governor_core.
module gdbg_chk (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    input  logic                             o_in_stall,
    input  logic                             o_out_valid,
    input  logic                             i_out_stall,
    input  gdbg_pkg::t_out_beat              o_out_data
);

    // A stalled result beat stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result beat dropped while stalled");

    // A stalled result beat keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_data))
        else $error("result payload changed while stalled");

    // Every accepted input beat gives a result beat in the next cycle
    a_in_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_out_valid)
        else $error("accepted beat gave no result");

    // Applying boost leaves it on and disarmed; removing it leaves it off
    a_boost_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.event_res == gdbg_pkg::EV_BOOST
                        || o_out_data.event_res == gdbg_pkg::EV_DEBOOST)
        |-> !o_out_data.boost_pending
            && (o_out_data.boost_on == (o_out_data.event_res == gdbg_pkg::EV_BOOST)))
        else $error("boost event disagrees with boost flags");

    // Request events agree with the full-speed flag
    a_req_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.event_res == gdbg_pkg::EV_FULL_REQ
                        || o_out_data.event_res == gdbg_pkg::EV_FULL_RELEASE)
        |-> o_out_data.full_speed_request
            == (o_out_data.event_res == gdbg_pkg::EV_FULL_REQ))
        else $error("request event disagrees with full-speed flag");

endmodule

bind gpu_dvfs_boost_governor_core gdbg_chk u_gdbg_chk (.*);

>>> tb/sv/governor_checker.sv
// Result checker for the GPU full-speed/boost governor: watches the three
// channels, predicts each result beat and compares it field by field.
// Depends on gdbg_pkg.
module governor_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                i_in_stall,
    input  gdbg_pkg::t_in_beat                  i_in_data,
    input  logic                                i_out_valid,
    input  logic                                i_out_stall,
    input  gdbg_pkg::t_out_beat                 i_out_data,
    input  logic                                i_cfg_valid,
    input  logic                                i_cfg_ready,
    input  logic [gdbg_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [gdbg_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output int unsigned                         o_fail_count,
    output int unsigned                         o_outstanding,
    output int unsigned                         o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    import gdbg_pkg::*;

    // Register copies
    logic [UTIL_W-1:0]  raise_thr;
    logic [UTIL_W-1:0]  release_thr;
    logic [UTIL_W-1:0]  up_level;
    logic [UTIL_W-1:0]  down_level;
    logic               allow_boost;
    logic [WAIT_W-1:0]  wait_ms;
    logic [LEVEL_W-1:0] low_index;
    logic [LEVEL_W-1:0] high_index;

    // Governor state copies
    logic               half_speed;
    logic               boost_want;
    logic               boost_armed;
    logic               boost_live;
    logic [WAIT_W-1:0]  countdown;

    t_out_beat   pending_results[$];
    int unsigned fails;
    int unsigned checked;

    assign o_fail_count  = fails;
    assign o_outstanding = pending_results.size();
    assign o_checked     = checked;

    // Advance the governor by one beat and return the result it gives
    function automatic t_out_beat next_governor_result(input t_in_beat b);
        t_out_beat   r;
        t_event      ev;
        logic        skip_boost;
        int unsigned idx;
        ev = EV_NONE;
        skip_boost = 1'b0;
        if (b.mode == MODE_TICK) begin
            // count down an armed change, apply it when it runs out
            if (boost_armed) begin
                if (countdown <= 1) begin
                    boost_live  = boost_want;
                    boost_armed = 1'b0;
                    countdown   = '0;
                    ev = boost_want ? EV_BOOST : EV_DEBOOST;
                end else begin
                    countdown = countdown - 1'b1;
                end
            end
        end else begin
            // hysteresis on the full-speed request
            if ((!boost_want && !boost_live && !boost_armed) || !allow_boost) begin
                if (b.utilization > raise_thr) begin
                    if (half_speed) begin
                        half_speed = 1'b0;
                        ev = EV_FULL_REQ;
                        skip_boost = 1'b1;
                    end
                end else if (b.utilization < release_thr) begin
                    if (!half_speed) begin
                        half_speed = 1'b1;
                        ev = EV_FULL_RELEASE;
                    end
                end
            end
            // arm, cancel or re-arm the delayed boost change
            if (!skip_boost && !half_speed && allow_boost) begin
                if (!boost_want && b.utilization > up_level) begin
                    boost_want = 1'b1;
                    if (!boost_armed) begin
                        boost_armed = 1'b1;
                        countdown   = wait_ms;
                    end else begin
                        boost_armed = 1'b0;
                        countdown   = '0;
                    end
                end else if (boost_want && !boost_live && b.utilization < down_level) begin
                    boost_want = 1'b0;
                    if (boost_armed) begin
                        boost_armed = 1'b0;
                        countdown   = '0;
                    end
                end else if (boost_live && b.utilization < down_level) begin
                    boost_want = 1'b0;
                    if (!boost_armed) begin
                        boost_armed = 1'b1;
                        countdown   = wait_ms;
                    end
                end
            end
        end
        idx = boost_live ? high_index : low_index;
        if (idx >= LEVEL_COUNT) idx = LEVEL_COUNT - 1;
        r.full_speed_request = !half_speed;
        r.boost_on           = boost_live;
        r.boost_pending      = boost_armed;
        r.level_index        = idx[LEVEL_W-1:0];
        r.event_res          = ev;
        return r;
    endfunction

    task automatic check_field(input string field, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d, actual %0d", $time, field, want, got);
            fails++;
        end
    endtask

    initial begin
        fails   = 0;
        checked = 0;
    end

    always @(posedge i_clk) begin : watch
        t_out_beat want;
        if (!i_rst_n) begin
            raise_thr   = RST_RAISE_THR;
            release_thr = RST_RELEASE_THR;
            up_level    = RST_BOOST_UP;
            down_level  = RST_BOOST_DOWN;
            allow_boost = RST_BOOST_ALLOW;
            wait_ms     = RST_WAIT_MS;
            low_index   = RST_LOW_INDEX;
            high_index  = RST_HIGH_INDEX;
            half_speed  = 1'b1;
            boost_want  = 1'b0;
            boost_armed = 1'b0;
            boost_live  = 1'b0;
            countdown   = '0;
            pending_results.delete();
        end else begin
            // take register writes
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_RAISE_THR:   raise_thr   = i_cfg_data[UTIL_W-1:0];
                    CFG_RELEASE_THR: release_thr = i_cfg_data[UTIL_W-1:0];
                    CFG_BOOST_UP:    up_level    = i_cfg_data[UTIL_W-1:0];
                    CFG_BOOST_DOWN:  down_level  = i_cfg_data[UTIL_W-1:0];
                    CFG_BOOST_ALLOW: allow_boost = i_cfg_data[0];
                    CFG_WAIT_MS:     wait_ms     = i_cfg_data[WAIT_W-1:0];
                    CFG_LOW_INDEX:   low_index   = i_cfg_data[LEVEL_W-1:0];
                    CFG_HIGH_INDEX:  high_index  = i_cfg_data[LEVEL_W-1:0];
                    default: ;
                endcase
            end
            // compare a result beat with the oldest expectation
            if (i_out_valid && !i_out_stall) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: result beat with nothing expected, actual %h",
                             $time, i_out_data);
                    fails++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("full_speed_request", 8'(want.full_speed_request),
                                8'(i_out_data.full_speed_request));
                    check_field("boost_on", 8'(want.boost_on), 8'(i_out_data.boost_on));
                    check_field("boost_pending", 8'(want.boost_pending),
                                8'(i_out_data.boost_pending));
                    check_field("level_index", 8'(want.level_index),
                                8'(i_out_data.level_index));
                    check_field("event_res", 8'(want.event_res), 8'(i_out_data.event_res));
                    checked++;
                end
            end
            // predict the result of an accepted input beat
            if (i_in_valid && !i_in_stall)
                pending_results.push_back(next_governor_result(i_in_data));
        end
    end

endmodule

>>> tb/sv/gpu_dvfs_boost_governor_core_tb.sv
// Testbench top for the GPU full-speed/boost governor: clock, reset,
// directed and random sample/tick beats, register phases and the verdict.
// Depends on gdbg_pkg, gpu_dvfs_boost_governor_core and governor_checker.
module gpu_dvfs_boost_governor_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gdbg_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200_000;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam int unsigned PHASE_BEATS = 225;

    typedef logic [CFG_DATA_W-1:0] t_reg_set [8];

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    t_in_beat              in_data   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    t_out_beat             out_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int unsigned fail_count;
    int unsigned outstanding;
    int unsigned checked;

    // Stimulus-side view of the registers, used to aim samples at thresholds
    t_reg_set    cur = '{RST_RAISE_THR, RST_RELEASE_THR, RST_BOOST_UP, RST_BOOST_DOWN,
                         RST_BOOST_ALLOW, RST_WAIT_MS, RST_LOW_INDEX, RST_HIGH_INDEX};
    int unsigned send_gap_pct  = 31;
    int unsigned stall_pct     = 31;
    int unsigned hold_requests = 0;
    int unsigned beats_sent    = 0;
    int unsigned settings_used = 0;
    int unsigned cycles        = 0;

    gpu_dvfs_boost_governor_core u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    governor_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_in_data     (in_data),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_out_data    (out_data),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding),
        .o_checked     (checked)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver: random stalls, or a long hold-off when one is requested
    initial begin : receiver
        int unsigned hold_left;
        int unsigned holds_seen;
        hold_left  = 0;
        holds_seen = 0;
        forever begin
            @(posedge clk);
            if (holds_seen != hold_requests) begin
                holds_seen = hold_requests;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                out_stall <= 1'b1;
                hold_left--;
            end else begin
                out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
            end
        end
    end

    // Give up on a hung run
    initial begin : watchdog
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("Mismatches found");
        $finish;
    end

    function automatic t_in_beat make_beat(input logic mode, input int unsigned util);
        t_in_beat b;
        b.mode        = mode;
        b.utilization = util[UTIL_W-1:0];
        return b;
    endfunction

    // Random beat, mostly aimed close to one of the thresholds
    function automatic t_in_beat random_beat();
        t_in_beat    b;
        int unsigned pick;
        int unsigned centre;
        int          v;
        b.mode = ($urandom_range(99) < 40) ? MODE_TICK : MODE_SAMPLE;
        pick = $urandom_range(99);
        if (pick < 20)      centre = cur[CFG_RAISE_THR] & 16'h1FF;
        else if (pick < 40) centre = cur[CFG_BOOST_UP] & 16'h1FF;
        else if (pick < 50) centre = cur[CFG_RELEASE_THR] & 16'h1FF;
        else                centre = cur[CFG_BOOST_DOWN] & 16'h1FF;
        if (pick < 60) begin
            v = int'(centre) + int'($urandom_range(4)) - 2;
            if (v < 0) v = 0;
            if (v > 511) v = 511;
            b.utilization = v[UTIL_W-1:0];
        end else if (pick < 90) begin
            b.utilization = UTIL_W'($urandom_range(256));
        end else begin
            b.utilization = UTIL_W'($urandom_range(511));
        end
        return b;
    endfunction

    // Random register set; unused upper data bits carry junk
    function automatic t_reg_set random_set();
        t_reg_set s;
        s[CFG_RAISE_THR]   = {7'($urandom), 9'($urandom_range(256))};
        s[CFG_RELEASE_THR] = {7'($urandom), 9'($urandom_range(256))};
        s[CFG_BOOST_UP]    = {7'($urandom), 9'($urandom_range(256))};
        s[CFG_BOOST_DOWN]  = {7'($urandom), 9'($urandom_range(256))};
        s[CFG_BOOST_ALLOW] = {15'($urandom), 1'($urandom_range(99) < 80)};
        s[CFG_WAIT_MS]     = 16'($urandom_range(6));
        s[CFG_LOW_INDEX]   = {9'($urandom), 7'($urandom)};
        s[CFG_HIGH_INDEX]  = {9'($urandom), 7'($urandom)};
        return s;
    endfunction

    // Offer one beat after a random gap and hold it until taken
    task automatic send_beat(input t_in_beat b);
        while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= b;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        beats_sent++;
    endtask

    // Occasionally slip a noise beat in front of a structured one
    task automatic send_shaped(input t_in_beat b);
        if ($urandom_range(99) < 12) send_beat(random_beat());
        send_beat(b);
    endtask

    // Stop offering and wait until every expected result has come
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    // Leave valid high so back-to-back writes need no drop
    task automatic write_reg(input t_cfg_reg idx, input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cur[idx] = value;
    endtask

    task automatic apply_settings(input t_reg_set s);
        for (int i = 0; i < 8; i++) write_reg(t_cfg_reg'(i), s[i]);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // Full speed, boost, its expiry, deboost, its expiry, release
    task automatic boost_cycle();
        int unsigned raise_v, up_v, low_v, wait_v, hi, lo, ticks;
        raise_v = cur[CFG_RAISE_THR] & 16'h1FF;
        up_v    = cur[CFG_BOOST_UP] & 16'h1FF;
        low_v   = cur[CFG_BOOST_DOWN] & 16'h1FF;
        if ((cur[CFG_RELEASE_THR] & 16'h1FF) < low_v) low_v = cur[CFG_RELEASE_THR] & 16'h1FF;
        wait_v  = cur[CFG_WAIT_MS];
        hi = ((raise_v > up_v) ? raise_v : up_v) + 1 + $urandom_range(3);
        if (hi > 511) hi = 511;
        lo = (low_v == 0) ? 0 : $urandom_range(low_v - 1);
        if (wait_v <= 8) ticks = (wait_v == 0) ? 1 : wait_v;
        else             ticks = $urandom_range(4, 1);
        send_shaped(make_beat(MODE_SAMPLE, hi));
        send_shaped(make_beat(MODE_SAMPLE, hi));
        repeat (ticks) send_shaped(make_beat(MODE_TICK, $urandom_range(511)));
        send_shaped(make_beat(MODE_SAMPLE, lo));
        repeat (ticks) send_shaped(make_beat(MODE_TICK, $urandom_range(511)));
        send_shaped(make_beat(MODE_SAMPLE, lo));
    endtask

    initial begin : stimulus
        t_reg_set    next_set;
        int unsigned phase_end;
        logic        paused;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset values: idle tick, threshold edges, arm then cancel, release
        send_beat(make_beat(MODE_TICK, 0));
        send_beat(make_beat(MODE_SAMPLE, 0));
        send_beat(make_beat(MODE_SAMPLE, 192));
        send_beat(make_beat(MODE_SAMPLE, 193));
        send_beat(make_beat(MODE_SAMPLE, 256));
        send_beat(make_beat(MODE_TICK, 0));
        send_beat(make_beat(MODE_SAMPLE, 63));
        send_beat(make_beat(MODE_SAMPLE, 63));

        // Zero wait: expiry on first tick, deboost re-arm cancelled, extreme indexes
        drain();
        apply_settings('{16'd100, 16'd50, 16'd150, 16'd40, 16'd1, 16'd0, 16'd0, 16'd127});
        send_beat(make_beat(MODE_SAMPLE, 511));
        send_beat(make_beat(MODE_SAMPLE, 300));
        send_beat(make_beat(MODE_TICK, 511));
        send_beat(make_beat(MODE_SAMPLE, 39));
        send_beat(make_beat(MODE_SAMPLE, 200));
        send_beat(make_beat(MODE_SAMPLE, 10));
        send_beat(make_beat(MODE_TICK, 0));
        send_beat(make_beat(MODE_SAMPLE, 0));

        // Boost switched off while a change is armed: it still expires
        drain();
        apply_settings('{16'd10, 16'd5, 16'd20, 16'd5, 16'd1, 16'd1, 16'd127, 16'd0});
        send_beat(make_beat(MODE_SAMPLE, 11));
        send_beat(make_beat(MODE_SAMPLE, 21));
        drain();
        write_reg(CFG_BOOST_ALLOW, 16'd0);
        cfg_valid <= 1'b0;
        send_beat(make_beat(MODE_TICK, 0));
        send_beat(make_beat(MODE_SAMPLE, 4));
        send_beat(make_beat(MODE_SAMPLE, 0));

        // Random phases, each under its own register set
        paused = 1'b0;
        for (int p = 0; p < 8; p++) begin
            case (p)
                1: next_set = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd1, 16'd0, 16'd0, 16'd0};
                2: next_set = '{16'h1FF, 16'h1FF, 16'h1FF, 16'h1FF, 16'd1, 16'hFFFF,
                                16'd127, 16'd127};
                5: next_set = '{16'd256, 16'd0, 16'd256, 16'd0, 16'd1, 16'd1,
                                16'd127, 16'd0};
                7: next_set = '{RST_RAISE_THR, RST_RELEASE_THR, RST_BOOST_UP,
                                RST_BOOST_DOWN, RST_BOOST_ALLOW, 16'd2,
                                RST_LOW_INDEX, RST_HIGH_INDEX};
                default: next_set = random_set();
            endcase
            if (p == 4) next_set[CFG_BOOST_ALLOW] = 16'd0;
            drain();
            apply_settings(next_set);
            send_gap_pct = (p == 3) ? 0 : 31;
            stall_pct    = (p == 3) ? 0 : 31;
            if (p == 0) hold_requests++;
            phase_end = beats_sent + PHASE_BEATS;
            while (beats_sent < phase_end) begin
                if (p == 6 && !paused && beats_sent + 110 >= phase_end) begin
                    drain();
                    paused = 1'b1;
                end
                if ($urandom_range(99) < 60) begin
                    boost_cycle();
                end else begin
                    repeat ($urandom_range(5, 1)) send_beat(random_beat());
                end
            end
        end

        drain();
        repeat (8) @(posedge clk);
        $display("Run covered %0d input beats and %0d checked result beats under %0d",
                 beats_sent, checked, settings_used);
        $display("register sets, with a long receiver hold-off and a mid-run drain pause.");
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
